// ----- rtl/core/lscs_pkg.sv -----
// shared types and constants for the line sensor calibrate and steer block
`default_nettype none

package lscs_pkg;

    localparam int CMD_W    = 2;
    localparam int ACTION_W = 3;
    localparam int CAL_LEN_W = 12;
    localparam int NUM_CH   = 3;

    localparam logic [CAL_LEN_W-1:0] CAL_LEN_RESET = 12'd3100;

    localparam logic [CMD_W-1:0] CMD_SEED      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CALIBRATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FOLLOW    = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_HOLD       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_FORWARD    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SPIN_RIGHT = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SPIN_LEFT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_STOP       = 3'd4;

    localparam int CH_LEFT   = 0;
    localparam int CH_CENTER = 1;
    localparam int CH_RIGHT  = 2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                calibration_done;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/lscs_if.sv -----
// item channel interfaces for the sensor input and the steering result
`default_nettype none

interface lscs_in_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             command;
    logic [SAMPLE_BITS-1:0] sample_left;
    logic [SAMPLE_BITS-1:0] sample_center;
    logic [SAMPLE_BITS-1:0] sample_right;

    modport source (
        output valid, command, sample_left, sample_center, sample_right,
        input  ready
    );
    modport sink (
        input  valid, command, sample_left, sample_center, sample_right,
        output ready
    );
endinterface

interface lscs_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic       calibration_done;

    modport source (
        output valid, action, calibration_done,
        input  ready
    );
    modport sink (
        input  valid, action, calibration_done,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/line_sensor_calibrate_and_steer.sv -----
// top level: input register, calibration core and result register
// throughput: one item per cycle while the receiver takes results,
// set by the state update in the core
// with the input register empty, an item is still accepted while a result waits
// reset: synchronous active low, clears both stage valids, min/max to zero,
// thresholds to mid-scale, sample count and done flag, calibration length to 3100
`default_nettype none

module line_sensor_calibrate_and_steer
    import lscs_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CAL_LEN_W-1:0] i_cfg_wdata,
    lscs_in_if.sink                   i_item,
    lscs_out_if.source                o_result
);

    logic [CAL_LEN_W-1:0]   r_cal_len;
    logic                   r_in_valid;
    logic [CMD_W-1:0]       r_command;
    logic [SAMPLE_BITS-1:0] r_left, r_center, r_right;
    logic                   r_out_valid;
    t_result                r_out;
    t_result                core_result;
    logic                   advance;
    logic                   fire;
    logic                   in_accept;

    assign advance   = !r_out_valid || o_result.ready;
    assign fire      = r_in_valid && advance;
    assign i_item.ready = !r_in_valid || advance;
    assign in_accept = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_len <= CAL_LEN_RESET;
        end else if (i_cfg_we) begin
            r_cal_len <= i_cfg_wdata;
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_command <= i_item.command;
            r_left    <= i_item.sample_left;
            r_center  <= i_item.sample_center;
            r_right   <= i_item.sample_right;
        end
    end

    lscs_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_cal_len (r_cal_len),
        .i_command (r_command),
        .i_left    (r_left),
        .i_center  (r_center),
        .i_right   (r_right),
        .o_result  (core_result)
    );

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_result;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.action           = r_out.action;
    assign o_result.calibration_done = r_out.calibration_done;

endmodule

`default_nettype wire

// ----- rtl/core/lscs_core.sv -----
// calibration state, threshold update and steering decision for one item
`default_nettype none

module lscs_core
    import lscs_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_fire,
    input  wire logic [CAL_LEN_W-1:0]   i_cal_len,
    input  wire logic [CMD_W-1:0]       i_command,
    input  wire logic [SAMPLE_BITS-1:0] i_left,
    input  wire logic [SAMPLE_BITS-1:0] i_center,
    input  wire logic [SAMPLE_BITS-1:0] i_right,
    output t_result                     o_result
);

    localparam logic [SAMPLE_BITS-1:0] MID_SCALE =
        SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

    logic [SAMPLE_BITS-1:0] r_min [NUM_CH];
    logic [SAMPLE_BITS-1:0] r_max [NUM_CH];
    logic [SAMPLE_BITS-1:0] r_thr [NUM_CH];
    logic [SAMPLE_BITS-1:0] n_min [NUM_CH];
    logic [SAMPLE_BITS-1:0] n_max [NUM_CH];
    logic [SAMPLE_BITS-1:0] n_thr [NUM_CH];
    logic [CAL_LEN_W-1:0]   r_count, n_count;
    logic                   r_done, n_done;
    logic [SAMPLE_BITS-1:0] rd [NUM_CH];

    assign rd[CH_LEFT]   = i_left;
    assign rd[CH_CENTER] = i_center;
    assign rd[CH_RIGHT]  = i_right;

    always_comb begin
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        logic [SAMPLE_BITS:0]   sum;
        logic                   finish;
        n_min   = r_min;
        n_max   = r_max;
        n_thr   = r_thr;
        n_count = r_count;
        n_done  = r_done;
        finish  = 1'b0;
        lo      = '0;
        hi      = '0;
        sum     = '0;
        o_result.action = ACT_HOLD;
        unique case (i_command)
            CMD_SEED: begin
                n_min   = rd;
                n_max   = rd;
                n_count = '0;
                n_done  = 1'b0;
            end
            CMD_CALIBRATE: begin
                if (!r_done) begin
                    n_count = r_count + CAL_LEN_W'(1);
                    finish  = (n_count >= i_cal_len);
                    for (int i = 0; i < NUM_CH; i++) begin
                        lo  = (rd[i] < r_min[i]) ? rd[i] : r_min[i];
                        hi  = (rd[i] > r_max[i]) ? rd[i] : r_max[i];
                        sum = {1'b0, lo} + {1'b0, hi};
                        n_min[i] = lo;
                        n_max[i] = hi;
                        if (finish) begin
                            n_thr[i] = sum[SAMPLE_BITS:1];
                        end
                    end
                    if (finish) begin
                        n_done = 1'b1;
                        o_result.action = ACT_STOP;
                    end else begin
                        o_result.action = ACT_SPIN_RIGHT;
                    end
                end
            end
            CMD_FOLLOW: begin
                if (rd[CH_CENTER] > r_thr[CH_CENTER]) begin
                    o_result.action = ACT_FORWARD;
                end else if (rd[CH_RIGHT] > r_thr[CH_RIGHT]) begin
                    o_result.action = ACT_SPIN_RIGHT;
                end else if (rd[CH_LEFT] > r_thr[CH_LEFT]) begin
                    o_result.action = ACT_SPIN_LEFT;
                end
            end
            default: begin
                o_result.action = ACT_HOLD;
            end
        endcase
        o_result.calibration_done = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_min[i] <= '0;
                r_max[i] <= '0;
                r_thr[i] <= MID_SCALE;
            end
            r_count <= '0;
            r_done  <= 1'b0;
        end else if (i_fire) begin
            r_min   <= n_min;
            r_max   <= n_max;
            r_thr   <= n_thr;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lscs_checker.sv -----
// port-level assertions for the line sensor calibrate and steer block
`default_nettype none

module lscs_checker
    import lscs_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic [ACTION_W-1:0] i_action,
    input wire logic                i_done
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    // every accepted item must be followed by a valid result
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |-> ##2 i_out_valid)
        else $error("accepted item produced no result");

    // an empty result stage never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result stage");

    // stop only comes with calibration done
    a_stop_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_action == ACT_STOP) |-> i_done)
        else $error("stop without calibration done");

    // no action code beyond stop
    a_action_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_action <= ACT_STOP))
        else $error("action code out of range");

endmodule

bind line_sensor_calibrate_and_steer lscs_checker u_lscs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_action    (o_result.action),
    .i_done      (o_result.calibration_done)
);

`default_nettype wire

// ----- tb/sv/tb_line_sensor_calibrate_and_steer.sv -----
// testbench for line_sensor_calibrate_and_steer: directed table, then random runs of all commands
`default_nettype none

module tb_line_sensor_calibrate_and_steer;
    import lscs_pkg::*;

    localparam int SW = 10;
    localparam int SMAX = (1 << SW) - 1;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int BLOCKS = 8;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic                 is_cfg;
        logic [CAL_LEN_W-1:0] len;
        logic [CMD_W-1:0]     cmd;
        logic [SW-1:0]        left;
        logic [SW-1:0]        center;
        logic [SW-1:0]        right;
        logic                 typed;
        logic [ACTION_W-1:0]  action;
        logic                 done;
    } t_row;

    localparam int NUM_ROWS = 28;
    localparam t_row SCRIPT [NUM_ROWS] = '{
        '{1'b0, 12'd0, CMD_FOLLOW, 10'd512, 10'd512, 10'd512, 1'b1, ACT_HOLD, 1'b0},
        '{1'b0, 12'd0, CMD_FOLLOW, 10'd0, 10'd513, 10'd0, 1'b1, ACT_FORWARD, 1'b0},
        '{1'b0, 12'd0, CMD_FOLLOW, 10'd0, 10'd512, 10'd513, 1'b1, ACT_SPIN_RIGHT, 1'b0},
        '{1'b0, 12'd0, CMD_FOLLOW, 10'd513, 10'd512, 10'd512, 1'b1, ACT_SPIN_LEFT, 1'b0},
        '{1'b0, 12'd0, CMD_FOLLOW, 10'd1023, 10'd1023, 10'd1023, 1'b1, ACT_FORWARD, 1'b0},
        '{1'b0, 12'd0, CMD_UNUSED, 10'd1023, 10'd1023, 10'd1023, 1'b1, ACT_HOLD, 1'b0},
        '{1'b0, 12'd0, CMD_CALIBRATE, 10'd1023, 10'd0, 10'd512, 1'b1, ACT_SPIN_RIGHT, 1'b0},
        '{1'b1, 12'd2, CMD_SEED, 10'd0, 10'd0, 10'd0, 1'b0, ACT_HOLD, 1'b0},
        '{1'b0, 12'd0, CMD_SEED, 10'd100, 10'd200, 10'd300, 1'b1, ACT_HOLD, 1'b0},
        '{1'b0, 12'd0, CMD_CALIBRATE, 10'd50, 10'd250, 10'd1023, 1'b1, ACT_SPIN_RIGHT, 1'b0},
        '{1'b0, 12'd0, CMD_CALIBRATE, 10'd1023, 10'd0, 10'd0, 1'b1, ACT_STOP, 1'b1},
        '{1'b0, 12'd0, CMD_CALIBRATE, 10'd0, 10'd0, 10'd0, 1'b1, ACT_HOLD, 1'b1},
        '{1'b0, 12'd0, CMD_FOLLOW, 10'd0, 10'd126, 10'd0, 1'b0, ACT_HOLD, 1'b0},
        '{1'b0, 12'd0, CMD_FOLLOW, 10'd0, 10'd125, 10'd512, 1'b0, ACT_HOLD, 1'b0},
        '{1'b0, 12'd0, CMD_FOLLOW, 10'd537, 10'd125, 10'd511, 1'b0, ACT_HOLD, 1'b0},
        '{1'b0, 12'd0, CMD_FOLLOW, 10'd536, 10'd125, 10'd511, 1'b0, ACT_HOLD, 1'b0},
        '{1'b1, 12'd0, CMD_SEED, 10'd0, 10'd0, 10'd0, 1'b0, ACT_HOLD, 1'b0},
        '{1'b0, 12'd0, CMD_SEED, 10'd1023, 10'd1023, 10'd1023, 1'b1, ACT_HOLD, 1'b0},
        '{1'b0, 12'd0, CMD_CALIBRATE, 10'd0, 10'd0, 10'd0, 1'b1, ACT_STOP, 1'b1},
        '{1'b1, 12'd4095, CMD_SEED, 10'd0, 10'd0, 10'd0, 1'b0, ACT_HOLD, 1'b0},
        '{1'b0, 12'd0, CMD_SEED, 10'd0, 10'd0, 10'd0, 1'b1, ACT_HOLD, 1'b0},
        '{1'b0, 12'd0, CMD_CALIBRATE, 10'd1023, 10'd1023, 10'd1023, 1'b1, ACT_SPIN_RIGHT, 1'b0},
        '{1'b0, 12'd0, CMD_CALIBRATE, 10'd0, 10'd1023, 10'd0, 1'b0, ACT_HOLD, 1'b0},
        '{1'b1, 12'd1, CMD_SEED, 10'd0, 10'd0, 10'd0, 1'b0, ACT_HOLD, 1'b0},
        '{1'b0, 12'd0, CMD_CALIBRATE, 10'd5, 10'd5, 10'd5, 1'b1, ACT_STOP, 1'b1},
        '{1'b0, 12'd0, CMD_UNUSED, 10'd0, 10'd0, 10'd0, 1'b1, ACT_HOLD, 1'b1},
        '{1'b0, 12'd0, CMD_FOLLOW, 10'd1023, 10'd1023, 10'd1023, 1'b0, ACT_HOLD, 1'b0},
        '{1'b0, 12'd0, CMD_SEED, 10'd0, 10'd0, 10'd0, 1'b0, ACT_HOLD, 1'b0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CAL_LEN_W-1:0] cfg_wdata;
    logic                 sink_ready = 1'b0;

    lscs_in_if #(.SAMPLE_BITS(SW)) in_if ();
    lscs_out_if out_if ();

    assign out_if.ready = sink_ready;

    line_sensor_calibrate_and_steer #(.SAMPLE_BITS(SW)) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (in_if),
        .o_result    (out_if)
    );

    // model state of the block
    logic [CAL_LEN_W-1:0] cal_len;
    logic [SW-1:0]        ch_min [NUM_CH];
    logic [SW-1:0]        ch_max [NUM_CH];
    logic [SW-1:0]        ch_thr [NUM_CH];
    logic [CAL_LEN_W-1:0] sample_count;
    logic                 cal_done;

    t_result pending_steering [$];
    int      fail_count = 0;
    int      steer_items = 0;
    int      cycle_count = 0;
    int      src_idle_pct = 0;
    int      snk_stall_pct = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("line_sensor_calibrate_and_steer regression: fail");
            $finish;
        end
    end

    function automatic t_result next_steering(input logic [CMD_W-1:0] cmd,
                                              input logic [SW-1:0] left,
                                              input logic [SW-1:0] center,
                                              input logic [SW-1:0] right);
        logic [SW-1:0] rd [NUM_CH];
        logic [SW:0]   sum;
        t_result       res;
        rd[CH_LEFT]   = left;
        rd[CH_CENTER] = center;
        rd[CH_RIGHT]  = right;
        res.action = ACT_HOLD;
        case (cmd)
            CMD_SEED: begin
                for (int i = 0; i < NUM_CH; i++) begin
                    ch_min[i] = rd[i];
                    ch_max[i] = rd[i];
                end
                sample_count = '0;
                cal_done = 1'b0;
            end
            CMD_CALIBRATE: begin
                if (!cal_done) begin
                    for (int i = 0; i < NUM_CH; i++) begin
                        if (rd[i] > ch_max[i]) ch_max[i] = rd[i];
                        if (rd[i] < ch_min[i]) ch_min[i] = rd[i];
                    end
                    sample_count = sample_count + 1'b1;
                    if (sample_count >= cal_len) begin
                        for (int i = 0; i < NUM_CH; i++) begin
                            sum = {1'b0, ch_min[i]} + {1'b0, ch_max[i]};
                            ch_thr[i] = sum[SW:1];
                        end
                        cal_done = 1'b1;
                        res.action = ACT_STOP;
                    end else begin
                        res.action = ACT_SPIN_RIGHT;
                    end
                end
            end
            CMD_FOLLOW: begin
                if (rd[CH_CENTER] > ch_thr[CH_CENTER]) res.action = ACT_FORWARD;
                else if (rd[CH_RIGHT] > ch_thr[CH_RIGHT]) res.action = ACT_SPIN_RIGHT;
                else if (rd[CH_LEFT] > ch_thr[CH_LEFT]) res.action = ACT_SPIN_LEFT;
            end
            default: ;
        endcase
        res.calibration_done = cal_done;
        return res;
    endfunction

    // calibrate readings lean on the rails so min and max spread out
    function automatic logic [SW-1:0] rail_sample();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return SW'(SMAX);
            default: return SW'($urandom_range(0, SMAX));
        endcase
    endfunction

    // follow readings sit near the threshold half of the time
    function automatic logic [SW-1:0] near_sample(input logic [SW-1:0] thr);
        int v;
        if ($urandom_range(0, 1)) return SW'($urandom_range(0, SMAX));
        v = int'(thr) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > SMAX) v = SMAX;
        return SW'(v);
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SW-1:0] left,
                             input logic [SW-1:0] center, input logic [SW-1:0] right,
                             input logic typed, input t_result want);
        t_result pred;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid         <= 1'b1;
        in_if.command       <= cmd;
        in_if.sample_left   <= left;
        in_if.sample_center <= center;
        in_if.sample_right  <= right;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        pred = next_steering(cmd, left, center, right);
        pending_steering.push_back(typed ? want : pred);
        if (cmd != CMD_UNUSED) steer_items++;
    endtask

    task automatic write_cal_len(input logic [CAL_LEN_W-1:0] len);
        in_if.valid <= 1'b0;
        while (pending_steering.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we  <= 1'b0;
        cal_len = len;
    endtask

    task automatic random_block(input int quota);
        int n;
        while (steer_items < quota) begin
            if ($urandom_range(0, 99) < 85) begin
                send_item(CMD_SEED, rail_sample(), rail_sample(), rail_sample(), 1'b0, '0);
                n = int'(cal_len) + int'($urandom_range(0, 3));
                if (n == 0) n = 1;
                repeat (n)
                    send_item(CMD_CALIBRATE, rail_sample(), rail_sample(), rail_sample(),
                              1'b0, '0);
                repeat ($urandom_range(3, 15))
                    send_item(CMD_FOLLOW, near_sample(ch_thr[CH_LEFT]),
                              near_sample(ch_thr[CH_CENTER]),
                              near_sample(ch_thr[CH_RIGHT]), 1'b0, '0);
            end else begin
                repeat ($urandom_range(1, 5))
                    send_item(CMD_CMD_W_RAND(), SW'($urandom_range(0, SMAX)),
                              SW'($urandom_range(0, SMAX)), SW'($urandom_range(0, SMAX)),
                              1'b0, '0);
            end
        end
    endtask

    function automatic logic [CMD_W-1:0] CMD_CMD_W_RAND();
        return CMD_W'($urandom_range(0, 3));
    endfunction

    // result checker and receiver stall
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (pending_steering.size() == 0) begin
                $error("unexpected result: action %0d calibration_done %0d",
                       out_if.action, out_if.calibration_done);
                fail_count++;
            end else begin
                want = pending_steering.pop_front();
                if (out_if.action !== want.action) begin
                    $error("action: expected %0d, actual %0d", want.action, out_if.action);
                    fail_count++;
                end
                if (out_if.calibration_done !== want.calibration_done) begin
                    $error("calibration_done: expected %0d, actual %0d",
                           want.calibration_done, out_if.calibration_done);
                    fail_count++;
                end
            end
        end
        sink_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    initial begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_wdata           <= '0;
        in_if.valid         <= 1'b0;
        in_if.command       <= CMD_SEED;
        in_if.sample_left   <= '0;
        in_if.sample_center <= '0;
        in_if.sample_right  <= '0;
        cal_len      = CAL_LEN_RESET;
        sample_count = '0;
        cal_done     = 1'b0;
        for (int i = 0; i < NUM_CH; i++) begin
            ch_min[i] = '0;
            ch_max[i] = '0;
            ch_thr[i] = SW'(1 << (SW - 1));
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[k]) begin
            if (SCRIPT[k].is_cfg) begin
                write_cal_len(SCRIPT[k].len);
            end else begin
                send_item(SCRIPT[k].cmd, SCRIPT[k].left, SCRIPT[k].center, SCRIPT[k].right,
                          SCRIPT[k].typed, '{action: SCRIPT[k].action,
                                             calibration_done: SCRIPT[k].done});
            end
        end

        for (int blk = 0; blk < BLOCKS; blk++) begin
            write_cal_len($urandom_range(0, 7) == 0 ? CAL_LEN_W'($urandom_range(0, 1))
                                                    : CAL_LEN_W'($urandom_range(2, 12)));
            case (blk % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 48; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 48; end
                default: begin src_idle_pct = 19; snk_stall_pct = 19; end
            endcase
            random_block(steer_items + RANDOM_ITEMS / BLOCKS);
        end
        in_if.valid <= 1'b0;

        while (pending_steering.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("line_sensor_calibrate_and_steer regression: pass");
        end else begin
            $display("line_sensor_calibrate_and_steer regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/lscs_pkg.sv
rtl/core/lscs_if.sv
rtl/core/lscs_core.sv
rtl/core/line_sensor_calibrate_and_steer.sv
rtl/core/lscs_checker.sv
tb/sv/tb_line_sensor_calibrate_and_steer.sv
